/* rtl/speech_segment_detector_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the speech segment detector
// Concurrent checks clocked by clk; compiled away for synthesis.
// ----------------------------------------------------------------------------
`ifndef SPEECH_SEGMENT_DETECTOR_ASSERT_SVH
`define SPEECH_SEGMENT_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS
`define SSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SSD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSD_ASSERT(lbl, prop, msg)
`define SSD_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* rtl/ssd_pkg.sv */
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, register indexes and reset values of the segment detector.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int CHUNK_SAMPLES_DEF  = 512;
  localparam int SAMPLES_PER_MS_DEF = 16;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int POS_W     = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTER_TH    = 3'd0,
    REG_EXIT_TH     = 3'd1,
    REG_MIN_SPEECH  = 3'd2,
    REG_MIN_SILENCE = 3'd3,
    REG_HOLD_OFF    = 3'd4
  } ssd_reg_t;

  localparam logic [CFG_W-1:0] ENTER_TH_RST    = 16'd32768;
  localparam logic [CFG_W-1:0] EXIT_TH_RST     = 16'd22938;
  localparam logic [CFG_W-1:0] MIN_SPEECH_RST  = 16'd250;
  localparam logic [CFG_W-1:0] MIN_SILENCE_RST = 16'd100;
  localparam logic [CFG_W-1:0] HOLD_OFF_RST    = 16'd98;

  typedef struct packed {
    logic [CFG_W-1:0] enter_threshold;
    logic [CFG_W-1:0] exit_threshold;
    logic [CFG_W-1:0] min_speech_ms;
    logic [CFG_W-1:0] min_silence_ms;
    logic [CFG_W-1:0] hold_off_ms;
  } ssd_cfg_t;

  typedef struct packed {
    logic [15:0] chunk_prob;
  } ssd_in_t;

  typedef struct packed {
    logic [POS_W-1:0] segment_start;
    logic [POS_W-1:0] segment_end;
  } ssd_out_t;

endpackage

/* rtl/ssd_stream_if.sv */
// ----------------------------------------------------------------------------
// ssd_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface ssd_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

/* rtl/ssd_cfg.sv */
// ----------------------------------------------------------------------------
// ssd_cfg
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module ssd_cfg
  import ssd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] index,
  input  logic [CFG_W-1:0]     wdata,
  output ssd_cfg_t             cfg
);

  ssd_cfg_t cfg_r;
  ssd_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (ssd_reg_t'(index))
        REG_ENTER_TH:    cfg_nxt.enter_threshold = wdata;
        REG_EXIT_TH:     cfg_nxt.exit_threshold  = wdata;
        REG_MIN_SPEECH:  cfg_nxt.min_speech_ms   = wdata;
        REG_MIN_SILENCE: cfg_nxt.min_silence_ms  = wdata;
        REG_HOLD_OFF:    cfg_nxt.hold_off_ms     = wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enter_threshold <= ENTER_TH_RST;
      cfg_r.exit_threshold  <= EXIT_TH_RST;
      cfg_r.min_speech_ms   <= MIN_SPEECH_RST;
      cfg_r.min_silence_ms  <= MIN_SILENCE_RST;
      cfg_r.hold_off_ms     <= HOLD_OFF_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/ssd_core.sv */
// ----------------------------------------------------------------------------
// ssd_core
// Segment state and combinational hysteresis update for one chunk.
// ----------------------------------------------------------------------------
module ssd_core
  import ssd_pkg::*;
#(
  parameter int CHUNK_SAMPLES  = CHUNK_SAMPLES_DEF,
  parameter int SAMPLES_PER_MS = SAMPLES_PER_MS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [15:0] prob,
  input  ssd_cfg_t    cfg,
  output logic        res_valid,
  output ssd_out_t    res
);

  localparam int SPM_W = $clog2(SAMPLES_PER_MS + 1);
  localparam int TH_W  = CFG_W + SPM_W;
  localparam logic [POS_W-1:0] CHUNK_INC = POS_W'(CHUNK_SAMPLES);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             in_speech_r, in_speech_nxt;
  logic [POS_W-1:0] sil_begin_r, sil_begin_nxt;
  logic             sil_valid_r, sil_valid_nxt;
  logic [POS_W-1:0] seg_begin_r, seg_begin_nxt;

  logic [TH_W-1:0]  hold_th, sil_th, speech_th;
  logic             is_enter, is_exit;
  logic [POS_W-1:0] sb, d_sil, d_seg;

  assign hold_th   = TH_W'(cfg.hold_off_ms)    * TH_W'(SAMPLES_PER_MS);
  assign sil_th    = TH_W'(cfg.min_silence_ms) * TH_W'(SAMPLES_PER_MS);
  assign speech_th = TH_W'(cfg.min_speech_ms)  * TH_W'(SAMPLES_PER_MS);

  always_comb begin
    pos_nxt       = pos_r + CHUNK_INC;
    in_speech_nxt = in_speech_r;
    sil_begin_nxt = sil_begin_r;
    sil_valid_nxt = sil_valid_r;
    seg_begin_nxt = seg_begin_r;
    is_enter      = prob >= cfg.enter_threshold;
    is_exit       = prob < cfg.exit_threshold;
    sb            = sil_begin_r;
    d_sil         = '0;
    d_seg         = '0;
    res_valid     = 1'b0;

    if (is_enter && !in_speech_r) begin
      in_speech_nxt = 1'b1;
      seg_begin_nxt = pos_nxt;
      sil_valid_nxt = 1'b0;
    end else begin
      sil_valid_nxt = sil_valid_r & ~is_enter;
      if (is_exit && in_speech_r) begin
        if (!sil_valid_nxt) begin
          sb            = pos_nxt;
          sil_valid_nxt = 1'b1;
        end
        sil_begin_nxt = sb;
        d_sil         = pos_nxt - sb;
        // confirmed end once hold-off passed and minimum silence reached
        if (!d_sil[POS_W-1] && d_sil > POS_W'(hold_th) && d_sil >= POS_W'(sil_th)) begin
          in_speech_nxt = 1'b0;
          d_seg         = sb - seg_begin_r;
          if (!d_seg[POS_W-1] && d_seg > POS_W'(speech_th)) begin
            res_valid     = 1'b1;
            seg_begin_nxt = '0;
          end
        end
      end
    end

    res.segment_start = seg_begin_r;
    res.segment_end   = sb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      in_speech_r <= 1'b0;
      sil_begin_r <= '0;
      sil_valid_r <= 1'b0;
      seg_begin_r <= '0;
    end else if (fire) begin
      pos_r       <= pos_nxt;
      in_speech_r <= in_speech_nxt;
      sil_begin_r <= sil_begin_nxt;
      sil_valid_r <= sil_valid_nxt;
      seg_begin_r <= seg_begin_nxt;
    end
  end

endmodule

/* rtl/speech_segment_detector.sv */
// ----------------------------------------------------------------------------
// speech_segment_detector: hysteresis voice-activity segmenter
// Input register then result register; 1 chunk per cycle when not stalled.
// Rate is set by the combinational segment state update in ssd_core.
// Synchronous active-low reset clears state, pipeline and config to defaults.
// ----------------------------------------------------------------------------
`include "speech_segment_detector_assert.svh"

module speech_segment_detector
  import ssd_pkg::*;
#(
  parameter int CHUNK_SAMPLES  = CHUNK_SAMPLES_DEF,
  parameter int SAMPLES_PER_MS = SAMPLES_PER_MS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ssd_stream_if.sink           in_stream,
  ssd_stream_if.source         out_stream,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  ssd_cfg_t    cfg;
  logic        stg_valid_r, stg_valid_nxt;
  logic [15:0] stg_prob_r;
  logic        out_valid_r, out_valid_nxt;
  ssd_out_t    out_data_r;
  logic        adv, stg_fire, in_fire;
  logic        res_valid;
  ssd_out_t    res;

  ssd_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  ssd_core #(
    .CHUNK_SAMPLES  (CHUNK_SAMPLES),
    .SAMPLES_PER_MS (SAMPLES_PER_MS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (stg_fire),
    .prob      (stg_prob_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  assign adv             = !out_valid_r || out_stream.ready;
  assign stg_fire        = stg_valid_r && adv;
  assign in_stream.ready = !stg_valid_r || adv;
  assign in_fire         = in_stream.valid && in_stream.ready;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_fire) begin
      stg_valid_nxt = 1'b1;
    end else if (stg_fire) begin
      stg_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = stg_fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_prob_r <= in_stream.payload.chunk_prob;
    end
    if (stg_fire && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_stream.valid   = out_valid_r;
  assign out_stream.payload = out_data_r;

  `SSD_ASSERT(a_stage_holds, stg_valid_r && out_valid_r && !out_stream.ready |=> stg_valid_r && $stable(stg_prob_r), "stalled stage item lost")
  `SSD_ASSERT(a_no_accept_full, !(in_stream.ready && stg_valid_r && out_valid_r && !out_stream.ready), "input accepted while pipeline full")
  `SSD_ASSERT(a_result_from_fire, $rose(out_valid_r) |-> $past(stg_fire), "result without stage transaction")
  `SSD_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid_r && !stg_valid_r, "pipeline not empty after reset")

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: speech segment detector testbench
// Streams speech probabilities into the segmenter with random idling on both
// sides. A local predictor tracks position, hysteresis and silence timing and
// queues each segment it expects. Every segment transaction is checked in
// order. Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import ssd_pkg::*;

  localparam int CHUNK               = CHUNK_SAMPLES_DEF;
  localparam int PER_MS              = SAMPLES_PER_MS_DEF;
  localparam int IDLE_PCT            = 24;
  localparam int RANDOM_ITEMS        = 700;
  localparam int PHASE_ITEMS         = 100;
  localparam int SINK_HOLD_CYCLES    = 200;
  localparam int DRAIN_CYCLES        = 8;
  localparam int CYCLE_LIMIT         = 200000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  ssd_stream_if #(.payload_t(ssd_in_t))  prob_if ();
  ssd_stream_if #(.payload_t(ssd_out_t)) seg_if ();

  speech_segment_detector #(
    .CHUNK_SAMPLES  (CHUNK),
    .SAMPLES_PER_MS (PER_MS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (prob_if),
    .out_stream (seg_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // predictor copy of registers and segmenter state
  logic [CFG_W-1:0] enter_th, exit_th, min_speech_ms, min_silence_ms, hold_off_ms;
  logic [POS_W-1:0] sample_pos, run_start, end_mark, seg_begin;
  logic             speaking, run_open;

  ssd_out_t    pending_segments[$];
  int          fail_count = 0;
  bit          no_idle = 1'b0;
  bit          sink_hold = 1'b0;
  int unsigned cycle_count = 0;

  function automatic logic [POS_W-1:0] ms_samples(input logic [CFG_W-1:0] ms);
    return POS_W'(ms) * POS_W'(PER_MS);
  endfunction

  // signed span strictly above a non-negative limit
  function automatic bit span_exceeds(input logic [POS_W-1:0] span,
                                      input logic [POS_W-1:0] lim);
    return !span[POS_W-1] && span > lim;
  endfunction

  function automatic void reset_segmenter();
    enter_th       = ENTER_TH_RST;
    exit_th        = EXIT_TH_RST;
    min_speech_ms  = MIN_SPEECH_RST;
    min_silence_ms = MIN_SILENCE_RST;
    hold_off_ms    = HOLD_OFF_RST;
    sample_pos     = '0;
    run_start      = '0;
    end_mark       = '0;
    seg_begin      = '0;
    speaking       = 1'b0;
    run_open       = 1'b0;
  endfunction

  function automatic void set_register(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] val);
    case (idx)
      REG_ENTER_TH:    enter_th       = val;
      REG_EXIT_TH:     exit_th        = val;
      REG_MIN_SPEECH:  min_speech_ms  = val;
      REG_MIN_SILENCE: min_silence_ms = val;
      REG_HOLD_OFF:    hold_off_ms    = val;
      default: ;
    endcase
  endfunction

  function automatic bit advance_segmenter(input logic [15:0] prob, output ssd_out_t seg);
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] gap;
    logic [POS_W-1:0] seg_end;
    seg = '0;
    sample_pos = sample_pos + POS_W'(CHUNK);
    pos = sample_pos;
    if (prob >= enter_th) begin
      run_open = 1'b0;
      if (!speaking) begin
        speaking  = 1'b1;
        seg_begin = pos;
        return 1'b0;
      end
    end
    if (prob < exit_th && speaking) begin
      if (!run_open) begin
        run_start = pos;
        run_open  = 1'b1;
      end
      if (!span_exceeds(pos - run_start, ms_samples(hold_off_ms)))
        return 1'b0;
      end_mark = run_start;
      gap = pos - end_mark;
      if (gap[POS_W-1] || gap < ms_samples(min_silence_ms))
        return 1'b0;
      seg_end  = end_mark;
      end_mark = '0;
      speaking = 1'b0;
      if (span_exceeds(seg_end - seg_begin, ms_samples(min_speech_ms))) begin
        seg.segment_start = seg_begin;
        seg.segment_end   = seg_end;
        seg_begin = '0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random ready, with one long hold-off on request
  initial begin
    seg_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold) begin
        seg_if.ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk);
        sink_hold = 1'b0;
      end else begin
        seg_if.ready <= no_idle || ($urandom_range(99, 0) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : check_segments
    ssd_out_t want;
    if (rst_n && seg_if.valid && seg_if.ready) begin
      if (pending_segments.size() == 0) begin
        $error("unexpected segment transaction: start=%0d end=%0d",
               seg_if.payload.segment_start, seg_if.payload.segment_end);
        fail_count++;
      end else begin
        want = pending_segments.pop_front();
        if (seg_if.payload.segment_start !== want.segment_start) begin
          $error("segment_start: expected %0d, got %0d",
                 want.segment_start, seg_if.payload.segment_start);
          fail_count++;
        end
        if (seg_if.payload.segment_end !== want.segment_end) begin
          $error("segment_end: expected %0d, got %0d",
                 want.segment_end, seg_if.payload.segment_end);
          fail_count++;
        end
      end
    end
  end

  // called and returns at a falling edge; valid is left high on return
  task automatic send_chunk(input logic [15:0] prob);
    ssd_out_t seg;
    bit       got;
    while (!no_idle && $urandom_range(99, 0) < IDLE_PCT) begin
      prob_if.valid <= 1'b0;
      @(negedge clk);
    end
    prob_if.valid   <= 1'b1;
    prob_if.payload <= ssd_in_t'(prob);
    @(posedge clk);
    while (!prob_if.ready) @(posedge clk);
    got = advance_segmenter(prob, seg);
    if (got) begin
      pending_segments.push_back(seg);
    end
    @(negedge clk);
  endtask

  task automatic wait_idle();
    prob_if.valid <= 1'b0;
    while (pending_segments.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    set_register(idx, val);
    @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] on_th, off_th, speech_ms,
                           silence_ms, hold_ms);
    wait_idle();
    write_reg(REG_ENTER_TH, on_th);
    write_reg(REG_EXIT_TH, off_th);
    write_reg(REG_MIN_SPEECH, speech_ms);
    write_reg(REG_MIN_SILENCE, silence_ms);
    write_reg(REG_HOLD_OFF, hold_ms);
  endtask

  function automatic logic [15:0] quiet_prob();
    if (exit_th == '0)
      return 16'($urandom);
    return 16'($urandom_range(exit_th - 1, 0));
  endfunction

  function automatic logic [15:0] loud_prob();
    return 16'($urandom_range(65535, enter_th));
  endfunction

  // talk burst then a pause, or a short burst of random chunks; some pauses are broken by a speech blip
  task automatic send_utterance(output int n);
    int talk;
    int pause;
    n = 0;
    if ($urandom_range(99, 0) < 15) begin
      repeat ($urandom_range(4, 1)) begin
        send_chunk(16'($urandom));
        n++;
      end
      return;
    end
    talk  = $urandom_range(20, 1);
    pause = $urandom_range(14, 1);
    repeat (talk) begin
      send_chunk(loud_prob());
      n++;
    end
    repeat (pause) begin
      if ($urandom_range(99, 0) < 5)
        send_chunk(loud_prob());
      else
        send_chunk(quiet_prob());
      n++;
    end
  endtask

  // threshold edges at reset values; segment too short to report
  task automatic test_reset_defaults();
    logic [15:0] probs [10];
    probs = '{16'd0, 16'd65535, 16'd32768, 16'd32767, 16'd22938,
              16'd22937, 16'd1, 16'd0, 16'd0, 16'd0};
    foreach (probs[i]) send_chunk(probs[i]);
  endtask

  // exit above enter: a chunk is speech and silence at once
  task automatic test_overlapping_thresholds();
    configure(16'd1000, 16'd60000, '0, '0, '0);
    send_chunk(16'd30000);
    send_chunk(16'd30000);
    send_chunk(16'd30000);
    send_chunk(16'd500);
    send_chunk(16'd500);
  endtask

  task automatic test_register_extremes();
    configure('1, '1, '1, '1, '1);
    send_chunk(16'd65535);
    send_chunk(16'd65534);
    send_chunk(16'd0);
    configure('0, '0, '0, '0, '0);
    send_chunk(16'd0);
    send_chunk(16'd65535);
    send_chunk(16'd12345);
    configure('1, '1, '0, '0, '0);
    send_chunk(16'd0);
    send_chunk(16'd0);
  endtask

  // indexes past the last register must not disturb any setting
  task automatic test_unused_index();
    wait_idle();
    for (int idx = int'(REG_HOLD_OFF) + 1; idx < (1 << CFG_IDX_W); idx++)
      write_reg(CFG_IDX_W'(idx), 16'($urandom));
    send_chunk(16'd65535);
    send_chunk(16'd0);
    send_chunk(16'd0);
  endtask

  // one segment per three chunks while results are held off
  task automatic test_backpressure();
    configure(16'd32768, 16'd32768, '0, '0, '0);
    sink_hold = 1'b1;
    repeat (25) begin
      send_chunk(loud_prob());
      send_chunk(quiet_prob());
      send_chunk(quiet_prob());
    end
    wait_idle();
  endtask

  task automatic test_random_segments();
    logic [CFG_W-1:0] on_th;
    logic [CFG_W-1:0] off_th;
    int sent;
    int phase;
    int n;
    sent  = 0;
    phase = 0;
    do begin
      on_th = 16'($urandom_range(60000, 4000));
      if ($urandom_range(4, 0) == 0)
        off_th = 16'($urandom_range(65535, on_th));
      else
        off_th = 16'($urandom_range(on_th, on_th / 4));
      if (phase == 1)
        configure(on_th, off_th, '0, '0, '0);
      else
        configure(on_th, off_th, 16'($urandom_range(200, 0)),
                  16'($urandom_range(120, 0)), 16'($urandom_range(120, 0)));
      no_idle = (phase == 3);
      n = 0;
      while (n < PHASE_ITEMS) begin
        int k;
        send_utterance(k);
        n += k;
      end
      sent += n;
      phase++;
    end while (sent < RANDOM_ITEMS);
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    prob_if.valid   = 1'b0;
    prob_if.payload = '0;
    reset_segmenter();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_overlapping_thresholds();
    test_register_extremes();
    test_unused_index();
    test_backpressure();
    test_random_segments();

    wait_idle();
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
